@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by derq_checker.sv.
// Needs clk and arst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DERQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define DERQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/derq_pkg.sv @@
// Types, codes and defaults for the double-ended ring queue.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package derq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int WORD_W    = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_PUSH_REAR  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_REAR   = 2'd2,
		CMD_POP_FRONT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t  cmd;
		word_t push_value;
	} req_t;

	typedef struct packed {
		word_t   pop_value;
		status_t status;
		logic    now_empty;
		logic    now_full;
	} rsp_t;

	// What every cell of the row does in a cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN,    // row moves away from the front, new word enters cell 0
		OP_SHIFT_OUT,   // row moves towards the front
		OP_WRITE_TAIL,  // cell just past the rear takes the word
		OP_CAR_LOAD,    // carrier row copies the data row
		OP_CAR_SHIFT    // carrier row moves one cell towards the front
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    word;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_DONE
	} fsm_t;

endpackage

`default_nettype wire

@@ hw/rtl/derq_cell.sv @@
// One storage cell of the queue row: a data word and a carrier word.
// Depends on derq_pkg.
`default_nettype none

module derq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 3
) (
	input  wire logic                 clk,
	input  wire derq_pkg::cell_ctl_t  ctl,
	input  wire logic [CW-1:0]        count,
	input  wire derq_pkg::word_t      d_lo,
	input  wire derq_pkg::word_t      d_hi,
	input  wire derq_pkg::word_t      c_hi,
	output derq_pkg::word_t           d,
	output derq_pkg::word_t           c
);
	import derq_pkg::*;

	word_t d_q;
	word_t car_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_SHIFT_IN:  d_q <= d_lo;
			OP_SHIFT_OUT: d_q <= d_hi;
			OP_WRITE_TAIL: begin
				if (count == CW'(IDX)) begin
					d_q <= ctl.word;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_CAR_LOAD:  car_q <= d_q;
			OP_CAR_SHIFT: car_q <= c_hi;
			default: ;
		endcase
	end

	assign d = d_q;
	assign c = car_q;

endmodule

`default_nettype wire

@@ hw/rtl/derq_ctrl.sv @@
// Sequencer of the queue: fill count, rear-read walk and response register.
// Depends on derq_pkg.
`default_nettype none

module derq_ctrl #(
	parameter int DEPTH = derq_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire derq_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output derq_pkg::rsp_t        rsp,
	input  wire derq_pkg::word_t  head_word,
	input  wire derq_pkg::word_t  car_word,
	output derq_pkg::cell_ctl_t   ctl,
	output logic [CW-1:0]         count
);
	import derq_pkg::*;

	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	fsm_t          state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] steps_q;
	rsp_t          rsp_q, rsp_d;
	logic          rsp_valid_q;
	logic          rsp_load;
	logic          out_free;
	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          walk_start;

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;
	assign is_full    = (count_q == CNT_FULL);
	assign is_empty   = (count_q == '0);
	// rear pop with more than one word held needs the carrier walk
	assign walk_start = accept && (req.cmd == CMD_POP_REAR) && !is_empty
		&& (count_q != CNT_ONE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (walk_start) state_d = FSM_WALK;
			FSM_WALK: if (steps_q == CNT_ONE) state_d = FSM_DONE;
			FSM_DONE: if (out_free) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctl.op    = OP_HOLD;
		ctl.word  = req.push_value;
		count_d   = count_q;
		rsp_load  = 1'b0;
		rsp_d.pop_value = '0;
		rsp_d.status    = STS_DONE;
		case (state_q)
			FSM_IDLE: begin
				req_ready = out_free;
				if (accept) begin
					if (req.cmd inside {CMD_PUSH_REAR, CMD_PUSH_FRONT}) begin
						if (is_full) begin
							rsp_d.status = STS_FULL;
						end else begin
							ctl.op  = (req.cmd == CMD_PUSH_REAR) ? OP_WRITE_TAIL : OP_SHIFT_IN;
							count_d = count_q + CNT_ONE;
						end
					end else if (is_empty) begin
						rsp_d.status = STS_EMPTY;
					end else begin
						count_d = count_q - CNT_ONE;
						if (req.cmd == CMD_POP_FRONT) begin
							ctl.op          = OP_SHIFT_OUT;
							rsp_d.pop_value = head_word;
						end else if (walk_start) begin
							ctl.op = OP_CAR_LOAD;
						end else begin
							rsp_d.pop_value = head_word;
						end
					end
					rsp_load = !walk_start;
				end
			end
			FSM_WALK: begin
				ctl.op = OP_CAR_SHIFT;
			end
			FSM_DONE: begin
				rsp_d.pop_value = car_word;
				rsp_load        = out_free;
			end
			default: ;
		endcase
		rsp_d.now_empty = (count_d == '0);
		rsp_d.now_full  = (count_d == CNT_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (walk_start) begin
			steps_q <= count_q - CNT_ONE;
		end else if (state_q == FSM_WALK) begin
			steps_q <= steps_q - CNT_ONE;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count     = count_q;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_ring_queue.sv @@
// Double-ended queue on a row of DEPTH-1 storage cells.
// Usage notes below. Depends on derq_pkg, derq_cell and derq_ctrl.
//
// Channels: req (cmd, push_value) with req_valid/req_ready, rsp (pop_value,
// status, now_empty, now_full) with rsp_valid/rsp_ready. Every request
// transaction gives exactly one response transaction, in order.
// The front word always sits in cell 0; the rear word in cell count-1.
// Pushes, front pops, rejected requests and rear pops with a single word held
// are answered directly: the response is registered at the accepting edge and
// can be taken at the next one. A rear pop with n >= 2 words held first walks
// the rear word down the carrier row one cell a cycle, then registers it.
// Throughput: one transaction a cycle except during that walk and while a response is stalled.
// Reset clears the fill count and the response valid flag; cell contents are
// left as they are and are never read before being written.
// When the receiver stalls, the response is held and req_ready drops until
// the response is taken.
`default_nettype none

module double_ended_ring_queue #(
	parameter int DEPTH = derq_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire derq_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output derq_pkg::rsp_t       rsp
);
	import derq_pkg::*;

	localparam int CW    = $clog2(DEPTH);
	localparam int NCELL = DEPTH - 1;

	cell_ctl_t     ctl;
	logic [CW-1:0] count;
	word_t         d_w [NCELL];
	word_t         c_w [NCELL];

	derq_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.head_word (d_w[0]),
		.car_word  (c_w[0]),
		.ctl       (ctl),
		.count     (count)
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		word_t d_lo;
		word_t d_hi;
		word_t c_hi;

		if (i == 0) begin : g_first
			assign d_lo = ctl.word;
		end else begin : g_mid_lo
			assign d_lo = d_w[i-1];
		end

		if (i == NCELL - 1) begin : g_last
			assign d_hi = '0;
			assign c_hi = '0;
		end else begin : g_mid_hi
			assign d_hi = d_w[i+1];
			assign c_hi = c_w[i+1];
		end

		derq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.count (count),
			.d_lo  (d_lo),
			.d_hi  (d_hi),
			.c_hi  (c_hi),
			.d     (d_w[i]),
			.c     (c_w[i])
		);
	end

endmodule

`default_nettype wire

@@ hw/rtl/derq_checker.sv @@
// Port-level checks for the double-ended ring queue, bound to the top level.
// Depends on derq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module derq_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire derq_pkg::rsp_t rsp
);
	import derq_pkg::*;

	logic full_rej;
	logic empty_rej;
	logic empty_ok;
	logic stalled;

	assign full_rej  = rsp_valid && (rsp.status == STS_FULL);
	assign empty_rej = rsp_valid && (rsp.status == STS_EMPTY);
	assign empty_ok  = rsp.now_empty && (rsp.pop_value == '0);
	assign stalled   = rsp_valid && !rsp_ready;

	`DERQ_ASSERT(a_full_flag, !full_rej || rsp.now_full, "full reject without full flag")
	`DERQ_ASSERT(a_empty_reject, !empty_rej || empty_ok, "empty reject with data or no flag")
	`DERQ_ASSERT(a_flags_excl, !(rsp_valid && rsp.now_empty && rsp.now_full), "empty and full")
	`DERQ_ASSERT(a_stall_blocks, !stalled || !req_ready, "request taken while stalled")
	`DERQ_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind double_ended_ring_queue derq_checker u_derq_checker (.*);

`default_nettype wire

@@ sim/deque_checker.sv @@
// Checker for the double-ended ring queue: mirrors the ring and its indices,
// predicts each response and compares it with what the block returns.
// Depends on derq_pkg for the request and response types.
`timescale 1ns / 100ps

module deque_checker #(
	parameter int DEPTH = derq_pkg::DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_ready,
	input  derq_pkg::req_t req,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_ready,
	input  derq_pkg::rsp_t rsp,
	output int             mismatches,
	output int             outstanding,
	output int             checked,
	output int             full_rejects,
	output int             empty_rejects
);

	import derq_pkg::*;

	word_t       ring [DEPTH];
	int unsigned front_pos;
	int unsigned back_pos;
	rsp_t        due_responses [$];

	function automatic bit ring_full();
		return ((back_pos + 1) % DEPTH) == front_pos;
	endfunction

	// Applies one request to the mirrored ring and returns the response it should give
	function automatic rsp_t predict_deque_op(req_t r);
		rsp_t res;
		res = '0;
		res.status = STS_DONE;
		if (r.cmd == CMD_PUSH_REAR || r.cmd == CMD_PUSH_FRONT) begin
			if (ring_full()) begin
				res.status = STS_FULL;
			end else if (r.cmd == CMD_PUSH_REAR) begin
				ring[back_pos] = r.push_value;
				back_pos = (back_pos + 1) % DEPTH;
			end else begin
				front_pos = (front_pos + DEPTH - 1) % DEPTH;
				ring[front_pos] = r.push_value;
			end
		end else begin
			if (front_pos == back_pos) begin
				res.status = STS_EMPTY;
			end else if (r.cmd == CMD_POP_REAR) begin
				back_pos = (back_pos + DEPTH - 1) % DEPTH;
				res.pop_value = ring[back_pos];
			end else begin
				res.pop_value = ring[front_pos];
				front_pos = (front_pos + 1) % DEPTH;
			end
		end
		res.now_empty = (front_pos == back_pos);
		res.now_full = ring_full();
		return res;
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			front_pos = 0;
			back_pos = 0;
			due_responses.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
			full_rejects = 0;
			empty_rejects = 0;
		end else begin
			// a response can never belong to a request accepted at the same edge
			if (rsp_valid && rsp_ready) begin
				if (due_responses.size() == 0) begin
					$display("%0t: response mismatch, expected none, got %h", $time, rsp);
					mismatches++;
				end else begin
					want = due_responses.pop_front();
					checked++;
					if (rsp.pop_value !== want.pop_value)
						flag("pop_value", want.pop_value, rsp.pop_value);
					if (rsp.status !== want.status)
						flag("status", want.status, rsp.status);
					if (rsp.now_empty !== want.now_empty)
						flag("now_empty", want.now_empty, rsp.now_empty);
					if (rsp.now_full !== want.now_full)
						flag("now_full", want.now_full, rsp.now_full);
				end
			end
			if (req_valid && req_ready) begin
				want = predict_deque_op(req);
				if (want.status == STS_FULL)
					full_rejects++;
				if (want.status == STS_EMPTY)
					empty_rejects++;
				due_responses.push_back(want);
			end
			outstanding = due_responses.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// Top of the double-ended ring queue testbench: clock, reset, request and
// response traffic with random stalls, watchdog and verdict.
// Depends on derq_pkg, double_ended_ring_queue and deque_checker.
`timescale 1ns / 100ps

module testbench;

	import derq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 950;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DRAIN_CYCLES   = 20;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int checked;
	int full_rejects;
	int empty_rejects;
	int items_sent;
	int quiet_cycles;

	double_ended_ring_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	deque_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.checked(checked),
		.full_rejects(full_rejects),
		.empty_rejects(empty_rejects)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic word_t random_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// push_pct steers the fill level so both full and empty get reached often
	function automatic cmd_t random_cmd(int push_pct);
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
	endfunction

	bit send_steady;

	task automatic send_request(input cmd_t c, input word_t v);
		int gap;
		if (items_sent % 32 == 0)
			send_steady = ($urandom_range(0, 3) == 0);
		gap = send_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: c, push_value: v};
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	initial begin : stimulus
		word_t corner_words [7];
		int phase_len;
		int push_pct;
		corner_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001};
		items_sent = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty queue, fill to the brim from both ends, rejected
		// pushes, drain from alternate ends, then empty pops again
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_POP_REAR, '1);
		for (int i = 0; i < DEPTH - 1; i++)
			send_request(i % 2 ? CMD_PUSH_FRONT : CMD_PUSH_REAR, corner_words[i % 7]);
		send_request(CMD_PUSH_REAR, 32'h1234_5678);
		send_request(CMD_PUSH_FRONT, 32'hfedc_ba98);
		for (int i = 0; i < DEPTH - 1; i++)
			send_request(i % 2 ? CMD_POP_FRONT : CMD_POP_REAR, random_word());
		send_request(CMD_POP_FRONT, random_word());
		send_request(CMD_POP_REAR, random_word());

		while (items_sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++)
				send_request(random_cmd(push_pct), random_word());
		end
		req_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d responses", items_sent, checked);
		$display("Pushes refused on a full ring: %0d, pops refused on an empty one: %0d",
			full_rejects, empty_rejects);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : rsp_side
		int stall;
		int taken;
		bit steady;
		taken = 0;
		steady = 1'b0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 32 == 0)
				steady = ($urandom_range(0, 3) == 0);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	// a rear pop of a nearly full ring walks down the carrier row, plus stalls
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n && !((req_valid && req_ready) || (rsp_valid && rsp_ready))) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

endmodule
